// ===== hw/rtl/rbw_pkg.sv =====
// Shared constants, types and arithmetic helpers of the rainbow frame generator.
`default_nettype none

package rbw_pkg;

  // Number of LEDs in one frame (valid range 1 to 8).
  localparam int LED_COUNT = 8;
  localparam int LED_CNT_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  localparam logic [7:0] SAT_RESET  = 8'd255;
  localparam logic [7:0] VAL_RESET  = 8'd255;
  localparam logic [7:0] STEP_RESET = 8'd8;

  // Control that travels with every color beat through the pipeline.
  typedef struct packed {
    logic       valid;
    logic [2:0] led_index;
    logic       last_led;
  } beat_tag_t;

  // Floor division by 255, exact for every dividend up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'd32897;
    return prod[30:23];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rbw_hsv_pipe.sv =====
// Seven-stage pipeline that turns an 8-bit LED phase into an RGB color.
`default_nettype none

module rbw_hsv_pipe (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire rbw_pkg::beat_tag_t in_tag,
  input  wire logic [7:0]        in_phase,
  input  wire logic [7:0]        sat,
  input  wire logic [7:0]        val,
  output rbw_pkg::beat_tag_t     out_tag,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue
);
  import rbw_pkg::*;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  beat_tag_t tag_r [1:7];

  logic [8:0]  hue1_r;
  sector_t     sec2_r, sec3_r, sec4_r, sec5_r, sec6_r, sec7_r;
  logic [5:0]  rem2_r;
  logic [7:0]  f3_r;
  logic [15:0] m_fs4_r, m_nf4_r, m_lo4_r;
  logic [7:0]  a_dn5_r, a_up5_r, lo5_r;
  logic [15:0] m_dn6_r, m_up6_r;
  logic [7:0]  lo6_r;
  logic [7:0]  dn7_r, up7_r, lo7_r;

  logic [16:0] hue_prod;
  sector_t     sec_nxt;
  logic [8:0]  rem_nxt;
  logic [9:0]  f_prod;

  assign hue_prod = 17'(in_phase) * 17'd359;
  assign f_prod   = 10'(rem2_r) * 10'd17;

  // Sector is hue / 60; hue never exceeds 358.
  always_comb begin
    priority if (hue1_r >= 9'd300) begin
      sec_nxt = SEC_MAG_RED;
      rem_nxt = hue1_r - 9'd300;
    end else if (hue1_r >= 9'd240) begin
      sec_nxt = SEC_BLU_MAG;
      rem_nxt = hue1_r - 9'd240;
    end else if (hue1_r >= 9'd180) begin
      sec_nxt = SEC_CYN_BLU;
      rem_nxt = hue1_r - 9'd180;
    end else if (hue1_r >= 9'd120) begin
      sec_nxt = SEC_GRN_CYN;
      rem_nxt = hue1_r - 9'd120;
    end else if (hue1_r >= 9'd60) begin
      sec_nxt = SEC_YEL_GRN;
      rem_nxt = hue1_r - 9'd60;
    end else begin
      sec_nxt = SEC_RED_YEL;
      rem_nxt = hue1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 7; k++) begin
        tag_r[k] <= '0;
      end
    end else if (adv) begin
      tag_r[1] <= in_tag;
      for (int k = 2; k <= 7; k++) begin
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue1_r  <= hue_prod[16:8];
      sec2_r  <= sec_nxt;
      rem2_r  <= rem_nxt[5:0];
      // 255 / 60 equals 17 / 4, so the scaled remainder is rem * 17 / 4.
      sec3_r  <= sec2_r;
      f3_r    <= f_prod[9:2];
      sec4_r  <= sec3_r;
      m_fs4_r <= 16'(f3_r) * 16'(sat);
      m_nf4_r <= 16'(8'd255 - f3_r) * 16'(sat);
      m_lo4_r <= 16'(8'd255 - sat) * 16'(val);
      sec5_r  <= sec4_r;
      a_dn5_r <= div255(m_fs4_r);
      a_up5_r <= div255(m_nf4_r);
      lo5_r   <= div255(m_lo4_r);
      sec6_r  <= sec5_r;
      m_dn6_r <= 16'(8'd255 - a_dn5_r) * 16'(val);
      m_up6_r <= 16'(8'd255 - a_up5_r) * 16'(val);
      lo6_r   <= lo5_r;
      sec7_r  <= sec6_r;
      dn7_r   <= div255(m_dn6_r);
      up7_r   <= div255(m_up6_r);
      lo7_r   <= lo6_r;
    end
  end

  assign out_tag = tag_r[7];

  always_comb begin
    unique case (sec7_r)
      SEC_RED_YEL: begin
        out_red = val;   out_green = up7_r; out_blue = lo7_r;
      end
      SEC_YEL_GRN: begin
        out_red = dn7_r; out_green = val;   out_blue = lo7_r;
      end
      SEC_GRN_CYN: begin
        out_red = lo7_r; out_green = val;   out_blue = up7_r;
      end
      SEC_CYN_BLU: begin
        out_red = lo7_r; out_green = dn7_r; out_blue = val;
      end
      SEC_BLU_MAG: begin
        out_red = up7_r; out_green = lo7_r; out_blue = val;
      end
      default: begin
        out_red = val;   out_green = lo7_r; out_blue = dn7_r;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rainbow_hsv_frame_generator.sv =====
// Top level of the rainbow frame generator: frame sequencer, registers, output stage.
//
// Usage: each beat accepted on the in_ channel carries a millisecond timestamp;
// bits 11 down to 4 of it form the animation phase of one frame. The block then
// sends LED_COUNT color beats on the out_ channel, in LED order, the last one
// flagged by out_last_led. LED i gets phase (base - i * phase_step) mod 256,
// hue phase * 359 / 256, and an integer HSV-to-RGB color with the configured
// saturation and value.
// Throughput: one color beat per cycle when the receiver never stalls. The frame
// sequencer sets that rate: it issues one LED a cycle while the pipeline advances
// and takes the next timestamp in the cycle its last LED issues.
// The first color of a frame passes the sequencer register, which loads at the edge
// that accepts the timestamp, then the seven stages of the color pipe and then the
// output register.
// Stalls: while out_valid is high and out_ready is low, the whole pipeline holds; no
// color is lost or repeated. The user must write the registers over the APB-style
// port (saturation at 0x0, value at 0x4, phase step at 0x8) only while the block is
// idle, which the block does not enforce. Reset: rst_n is synchronous and active
// low; it empties the pipeline and loads saturation 255, value 255 and phase step 8.
`default_nettype none

module rainbow_hsv_frame_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_time_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_led_index,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_last_led,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rbw_pkg::*;

  typedef enum logic [1:0] {
    REG_SATURATION = 2'd0,
    REG_VALUE      = 2'd1,
    REG_PHASE_STEP = 2'd2,
    REG_NONE       = 2'd3
  } reg_index_t;

  localparam logic [LED_CNT_W-1:0] LED_LAST = LED_CNT_W'(LED_COUNT - 1);

  // Configuration registers.
  logic [7:0] sat_r, val_r, step_r;
  reg_index_t reg_sel;
  logic       cfg_wr;

  // Frame sequencer.
  logic                 busy_r, busy_nxt;
  logic [LED_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]           ph_r, ph_nxt;

  logic      adv;
  logic      last_issue;
  logic      in_fire;
  beat_tag_t seq_tag;
  beat_tag_t pipe_tag;
  logic [7:0] pipe_red, pipe_green, pipe_blue;

  logic       out_valid_r;
  logic [2:0] out_idx_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r;
  logic       out_last_r;

  // APB-style register access; an address past the phase step is ignored.
  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r  <= SAT_RESET;
      val_r  <= VAL_RESET;
      step_r <= STEP_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_SATURATION: sat_r  <= pwdata[7:0];
        REG_VALUE:      val_r  <= pwdata[7:0];
        REG_PHASE_STEP: step_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SATURATION: prdata = {24'd0, sat_r};
      REG_VALUE:      prdata = {24'd0, val_r};
      REG_PHASE_STEP: prdata = {24'd0, step_r};
      default:        prdata = 32'd0;
    endcase
  end

  // The pipeline moves as one whenever the output register can take a beat.
  assign adv        = !out_valid_r || out_ready;
  assign last_issue = busy_r && (cnt_r == LED_LAST);
  assign in_ready   = !busy_r || (adv && last_issue);
  assign in_fire    = in_valid && in_ready;

  // The sequencer walks the LEDs, stepping the phase down by phase_step each time.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    ph_nxt   = ph_r;
    if (busy_r && adv) begin
      if (last_issue) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        ph_nxt  = ph_r - step_r;
      end
    end
    if (in_fire) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      ph_nxt   = in_time_ms[11:4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r <= ph_nxt;
  end

  assign seq_tag.valid     = busy_r;
  assign seq_tag.led_index = 3'(cnt_r);
  assign seq_tag.last_led  = last_issue;

  rbw_hsv_pipe u_hsv_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_tag    (seq_tag),
    .in_phase  (ph_r),
    .sat       (sat_r),
    .val       (val_r),
    .out_tag   (pipe_tag),
    .out_red   (pipe_red),
    .out_green (pipe_green),
    .out_blue  (pipe_blue)
  );

  // Output register: holds a color beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= pipe_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r   <= pipe_tag.led_index;
      out_last_r  <= pipe_tag.last_led;
      out_red_r   <= pipe_red;
      out_green_r <= pipe_green;
      out_blue_r  <= pipe_blue;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_led_index = out_idx_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_last_led  = out_last_r;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of the rainbow frame generator with its own color predictor.
`timescale 1ns / 100ps

module tb;
  import rbw_pkg::*;

  // Register indexes of the configuration port; the byte address is four times the index.
  localparam int REG_SATURATION = 0;
  localparam int REG_VALUE      = 1;
  localparam int REG_PHASE_STEP = 2;
  localparam int REG_UNMAPPED   = 3;

  // Cycles that may pass with nothing accepted on either channel before the run is abandoned.
  // The slowest correct gap is a receiver stall plus the pipeline and a reconfiguration
  // pause, so this leaves a wide margin.
  localparam int STALL_LIMIT = 2000;
  // Cycles allowed for the pipeline to drain after the last color has arrived.
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_PER_PHASE = 42;

  // One color beat as it is expected on the result channel.
  typedef struct packed {
    logic [2:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_led;
  } led_color_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [31:0] in_time_ms = '0;
  logic        out_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  wire logic        in_ready;
  wire logic        out_valid;
  wire logic [2:0]  out_led_index;
  wire logic [7:0]  out_red;
  wire logic [7:0]  out_green;
  wire logic [7:0]  out_blue;
  wire logic        out_last_led;
  wire logic [31:0] prdata;
  wire logic        pready;

  rainbow_hsv_frame_generator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_time_ms   (in_time_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_led_index(out_led_index),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_last_led (out_last_led),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copies of the block's registers, kept in step with every write on the port.
  logic [7:0] sat_shadow = SAT_RESET;
  logic [7:0] val_shadow = VAL_RESET;
  logic [7:0] step_shadow = STEP_RESET;

  logic [31:0] stamp_q[$];       // timestamps waiting to be driven
  led_color_t  color_q[$];       // colors predicted but not yet seen
  bit          idling_on = 1'b1; // random bursts of idle cycles on both channels
  int          bad_beats = 0;
  int          quiet_cycles = 0;

  // Integer HSV-to-RGB conversion of one LED phase with the given saturation and value.
  function automatic led_color_t hsv_to_rgb(input logic [7:0] phase, input logic [7:0] sat,
                                            input logic [7:0] val);
    int unsigned hue, frac, s, v, lo, dn, up;
    led_color_t c;
    s = sat;
    v = val;
    hue = 32'(phase) * 359 / 256;
    frac = (hue % 60) * 255 / 60;
    lo = (255 - s) * v / 255;
    dn = (255 - frac * s / 255) * v / 255;
    up = (255 - (255 - frac) * s / 255) * v / 255;
    c = '0;
    // The hue tops out at 357, so the sector never goes past five.
    case (hue / 60)
      0: begin
        c.red = 8'(v);  c.green = 8'(up); c.blue = 8'(lo);
      end
      1: begin
        c.red = 8'(dn); c.green = 8'(v);  c.blue = 8'(lo);
      end
      2: begin
        c.red = 8'(lo); c.green = 8'(v);  c.blue = 8'(up);
      end
      3: begin
        c.red = 8'(lo); c.green = 8'(dn); c.blue = 8'(v);
      end
      4: begin
        c.red = 8'(up); c.green = 8'(lo); c.blue = 8'(v);
      end
      default: begin
        c.red = 8'(v);  c.green = 8'(lo); c.blue = 8'(dn);
      end
    endcase
    return c;
  endfunction

  // Queues the whole frame of colors that one timestamp produces, in LED order.
  function automatic void predict_frame(input logic [31:0] stamp);
    logic [7:0] base, phase;
    led_color_t c;
    base = stamp[11:4];
    for (int i = 0; i < LED_COUNT; i++) begin
      // The per-LED phase wraps modulo 256 when the offset runs past zero.
      phase = base - 8'(i * int'(step_shadow));
      c = hsv_to_rgb(phase, sat_shadow, val_shadow);
      c.led_index = 3'(i);
      c.last_led = (i == LED_COUNT - 1);
      color_q.push_back(c);
    end
  endfunction

  // Input driver. When the current beat is accepted (or none is offered), it either
  // starts an idle burst or presents the next queued timestamp; valid stays high
  // across back-to-back beats without dropping in between.
  int stamp_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      stamp_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_frame(in_time_ms);
      end
      if (!in_valid || in_ready) begin
        if (stamp_gap > 0) begin
          in_valid <= 1'b0;
          stamp_gap <= stamp_gap - 1;
        end else if (stamp_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          stamp_gap <= $urandom_range(0, 18);
        end else begin
          in_valid <= 1'b1;
          in_time_ms <= stamp_q.pop_front();
        end
      end
    end
  end

  // Result monitor. Every accepted color is checked against the oldest prediction,
  // and out_ready is dropped in random bursts to exercise the pipeline hold.
  int color_gap = 0;
  always @(posedge clk) begin
    led_color_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      color_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (color_q.size() == 0) begin
          bad_beats <= bad_beats + 1;
          if (bad_beats < 10) begin
            $display("unexpected color beat: led %0d rgb %02h %02h %02h last %0b",
                     out_led_index, out_red, out_green, out_blue, out_last_led);
          end
        end else begin
          want = color_q.pop_front();
          if (out_led_index !== want.led_index || out_red !== want.red ||
              out_green !== want.green || out_blue !== want.blue ||
              out_last_led !== want.last_led) begin
            bad_beats <= bad_beats + 1;
            if (bad_beats < 10) begin
              $display({"color mismatch: expected led %0d rgb %02h %02h %02h last %0b,",
                        " got led %0d rgb %02h %02h %02h last %0b"},
                       want.led_index, want.red, want.green, want.blue, want.last_led,
                       out_led_index, out_red, out_green, out_blue, out_last_led);
            end
          end
        end
      end
      if (color_gap > 0) begin
        out_ready <= 1'b0;
        color_gap <= color_gap - 1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        color_gap <= $urandom_range(0, 18);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a run in which neither channel moves for too long has hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL rainbow_hsv_frame_generator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Writes one register over the port: a setup cycle, then an access cycle. The upper
  // data bits carry noise, since only the low byte is stored.
  task automatic write_reg(input int idx, input logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(4 * idx);
    pwdata <= {24'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SATURATION: sat_shadow = value;
      REG_VALUE:      val_shadow = value;
      REG_PHASE_STEP: step_shadow = value;
      default: ;
    endcase
  endtask

  // Blocks until every queued timestamp is accepted and every predicted color has
  // arrived, then lets the pipeline settle so that the block is idle.
  task automatic wait_drained();
    while (stamp_q.size() != 0 || in_valid || color_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Settings visited after the directed part: saturation, value, phase step.
  logic [7:0] sat_list[7]  = '{8'd0,   8'd255, 8'd128, 8'd1,   8'd254, 8'd200, 8'd255};
  logic [7:0] val_list[7]  = '{8'd255, 8'd0,   8'd200, 8'd1,   8'd255, 8'd77,  8'd255};
  logic [7:0] step_list[7] = '{8'd0,   8'd255, 8'd1,   8'd128, 8'd37,  8'd200, 8'd32};
  // Phases on both sides of every sixty-degree hue boundary, plus both ends.
  logic [7:0] edge_phases[12] = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd128,
                                  8'd129, 8'd171, 8'd172, 8'd213, 8'd214, 8'd255};

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset settings. The timestamp bits outside 11..4 are
    // filled with noise or all ones, as the block must ignore them; a phase step of
    // 8 from low phases also makes the per-LED phase wrap below zero.
    stamp_q.push_back(32'h0000_0000);
    stamp_q.push_back(32'hFFFF_FFFF);
    stamp_q.push_back(32'h0000_0FF0);
    stamp_q.push_back(32'hFFFF_F00F);
    foreach (edge_phases[k]) begin
      stamp_q.push_back({20'($urandom), edge_phases[k], 4'($urandom)});
    end
    wait_drained();

    // A write beyond the last register must leave every register unchanged.
    write_reg(REG_UNMAPPED, 8'h5A);
    stamp_q.push_back(32'h0000_0330);
    stamp_q.push_back(32'h0000_0010);
    wait_drained();

    // Random frames under each setting. Idling is off in the fourth phase and in the
    // final one, so that long stretches run at full rate.
    for (int p = 0; p < 7; p++) begin
      write_reg(REG_SATURATION, sat_list[p]);
      write_reg(REG_VALUE, val_list[p]);
      write_reg(REG_PHASE_STEP, step_list[p]);
      idling_on = (p < 6) && (p != 3);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        stamp_q.push_back($urandom);
      end
      wait_drained();
    end

    if (bad_beats == 0 && color_q.size() == 0) begin
      $display("PASS rainbow_hsv_frame_generator");
    end else begin
      $display("FAIL rainbow_hsv_frame_generator");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rbw_pkg.sv
hw/rtl/rbw_hsv_pipe.sv
hw/rtl/rainbow_hsv_frame_generator.sv
tb/tb.sv
